// ----- sv/fss_pkg.sv -----
// ----------------------------------------------------------------------------
// fss_pkg: shared types of the forest subtree sum block
// Node index, count and total widths, the controller to datapath command and status.
// ----------------------------------------------------------------------------
package fss_pkg;
	localparam int IDX_W   = 6;
	localparam int SLOTS   = 64;
	localparam int CNT_W   = 7;
	localparam int TOT_W   = 37;
	localparam int MAXW    = 57;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [TOT_W-1:0] tot_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_COUNT,
		OP_SEED,
		OP_POP,
		OP_ADD,
		OP_EMIT,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t  op;
		idx_t idx;
	} cmd_t;

	typedef struct packed {
		logic has_par;
		logic q_empty;
		idx_t q_node;
	} stat_t;
endpackage

// ----- sv/fss_if.sv -----
// ----------------------------------------------------------------------------
// fss_in_if / fss_out_if: valid/ready channels of the block
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface fss_in_if #(parameter int WEIGHT_BITS = 32);
	logic                   valid;
	logic                   ready;
	logic [5:0]             parent_index;
	logic                   has_parent;
	logic [WEIGHT_BITS-1:0] weight;
	logic                   last;
	modport source (output valid, parent_index, has_parent, weight, last, input ready);
	modport sink (input valid, parent_index, has_parent, weight, last, output ready);
endinterface

interface fss_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  node_index;
	logic [36:0] subtree_total;
	logic        last_res;
	modport source (output valid, node_index, subtree_total, last_res, input ready);
	modport sink (input valid, node_index, subtree_total, last_res, output ready);
endinterface

// ----- sv/forest_subtree_sum.sv -----
// ----------------------------------------------------------------------------
// forest_subtree_sum: subtree totals of a parent-pointer forest
// Loads nodes, then propagates totals to parents in topological order.
// ----------------------------------------------------------------------------
// Load accepts one node word per cycle; after the last word, the child count,
// seeding, queue drain and emit passes run in turn, and each emitted word
// waits until the output accepts it.
// No new word is taken until the last result word of a forest is accepted.
// Reset clears the node count and queue pointers; child counts are zeroed as
// each node loads, and node stores are undefined until loaded.
module forest_subtree_sum #(
	parameter int MAX_NODES   = 64,
	parameter int WEIGHT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	fss_in_if.sink   in_ch,
	fss_out_if.source out_ch
);
	import fss_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	cnt_t  n;
	tot_t  rd_total;

	fss_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_idx(out_ch.node_index), .out_last(out_ch.last_res),
		.cmd, .n, .stat
	);

	fss_datapath #(.WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk, .arst_n, .cmd,
		.ld_par(in_ch.parent_index), .ld_has(in_ch.has_parent),
		.ld_weight(in_ch.weight), .n, .stat, .rd_total
	);

	assign out_ch.subtree_total = rd_total;
endmodule

// ----- sv/fss_datapath.sv -----
// ----------------------------------------------------------------------------
// fss_datapath: node stores, child counts, ready queue and total adder
// Executes one command per cycle; store reads are registered.
// ----------------------------------------------------------------------------
module fss_datapath #(
	parameter int WEIGHT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fss_pkg::cmd_t          cmd,
	input  logic [5:0]             ld_par,
	input  logic                   ld_has,
	input  logic [WEIGHT_BITS-1:0] ld_weight,
	input  fss_pkg::cnt_t          n,
	output fss_pkg::stat_t         stat,
	output fss_pkg::tot_t          rd_total
);
	import fss_pkg::*;

	idx_t par_mem [SLOTS];
	logic has_mem [SLOTS];
	tot_t tot_mem [SLOTS];
	idx_t queue_mem [SLOTS];
	cnt_t pend_mem [SLOTS];
	cnt_t head_q, tail_q;
	idx_t par_q;
	logic has_q;
	tot_t child_tot_q;
	tot_t par_tot_q;
	cnt_t pend_self_q;
	cnt_t pend_par_q;
	idx_t q_node_q;
	logic [TOT_W:0] sum;
	tot_t clamped;
	logic pend_zero;
	logic par_done;

	always_comb begin
		if (ld_weight[WEIGHT_BITS-1])
			clamped = '0;
		else if (WEIGHT_BITS - 1 > TOT_W
				&& (MAXW'(ld_weight) >> TOT_W) != '0)
			clamped = '1;
		else
			clamped = TOT_W'(MAXW'(ld_weight));
		sum = {1'b0, par_tot_q} + {1'b0, child_tot_q};
	end

	assign pend_zero = (pend_self_q == '0);
	assign par_done = (pend_par_q == CNT_W'(1));

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				par_mem[cmd.idx] <= ld_par;
				has_mem[cmd.idx] <= ld_has;
				tot_mem[cmd.idx] <= clamped;
			end
			OP_ADD: tot_mem[par_q] <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
			default: ;
		endcase
		case (cmd.op)
			OP_LOAD: pend_mem[cmd.idx] <= '0;
			OP_COUNT: if (stat.has_par) pend_mem[par_q] <= pend_par_q + 1'b1;
			OP_ADD: pend_mem[par_q] <= pend_par_q - 1'b1;
			default: ;
		endcase
		case (cmd.op)
			OP_SEED: if (pend_zero) queue_mem[tail_q[IDX_W-1:0]] <= cmd.idx;
			OP_ADD: if (par_done) queue_mem[tail_q[IDX_W-1:0]] <= par_q;
			default: ;
		endcase
		par_q <= par_mem[cmd.idx];
		has_q <= has_mem[cmd.idx];
		child_tot_q <= tot_mem[cmd.idx];
		par_tot_q <= tot_mem[par_q];
		pend_self_q <= pend_mem[cmd.idx];
		pend_par_q <= pend_mem[par_q];
		q_node_q <= queue_mem[head_q[IDX_W-1:0]];
	end

	assign rd_total = child_tot_q;

	always_comb begin
		stat.has_par = has_q && ({1'b0, par_q} < n);
		stat.q_empty = (head_q == tail_q);
		stat.q_node = q_node_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			case (cmd.op)
				OP_SEED: if (pend_zero) tail_q <= tail_q + 1'b1;
				OP_POP: head_q <= head_q + 1'b1;
				OP_ADD: if (par_done) tail_q <= tail_q + 1'b1;
				OP_CLEAR: begin
					head_q <= '0;
					tail_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) head_q <= tail_q)
		else $error("queue head passed tail");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CLEAR |=> head_q == '0 && tail_q == '0)
		else $error("clear did not reset queue");
	assert property (@(posedge clk) disable iff (!arst_n) tail_q <= CNT_W'(SLOTS))
		else $error("queue overflow");
endmodule

// ----- sv/fss_ctrl.sv -----
// ----------------------------------------------------------------------------
// fss_ctrl: sequencer of the load, count, seed, drain and emit passes
// Issues datapath commands and runs the output register.
// ----------------------------------------------------------------------------
module fss_ctrl #(
	parameter int MAX_NODES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_last,
	output logic           out_valid,
	input  logic           out_ready,
	output fss_pkg::idx_t  out_idx,
	output logic           out_last,
	output fss_pkg::cmd_t  cmd,
	output fss_pkg::cnt_t  n,
	input  fss_pkg::stat_t stat
);
	import fss_pkg::*;

	typedef enum logic [3:0] {
		S_LOAD, S_CNT_RD, S_CNT_WAIT, S_CNT_UP, S_SEED_RD, S_SEED, S_POP, S_POP_RD,
		S_ADD_RD, S_ADD, S_EM_WAIT, S_EM_OUT
	} state_t;

	state_t state_q;
	cnt_t   i_q;
	idx_t   node_q;

	assign in_ready = (state_q == S_LOAD);

	always_comb begin
		cmd = '{op: OP_NONE, idx: i_q[IDX_W-1:0]};
		case (state_q)
			S_LOAD: begin
				cmd.idx = n[IDX_W-1:0];
				if (in_valid && n < CNT_W'(MAX_NODES)) cmd.op = OP_LOAD;
			end
			S_CNT_UP: cmd.op = OP_COUNT;
			S_SEED: cmd.op = OP_SEED;
			S_POP: if (!stat.q_empty) cmd.op = OP_POP;
			S_POP_RD: cmd.idx = stat.q_node;
			S_ADD_RD: cmd.idx = node_q;
			S_ADD: begin
				cmd.idx = node_q;
				if (stat.has_par) cmd.op = OP_ADD;
			end
			S_EM_WAIT: if (i_q == n) cmd.op = OP_CLEAR;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			i_q <= '0;
			n <= '0;
			node_q <= '0;
			out_valid <= 1'b0;
			out_idx <= '0;
			out_last <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: if (in_valid) begin
					if (n < CNT_W'(MAX_NODES)) n <= n + 1'b1;
					if (in_last) begin
						i_q <= '0;
						state_q <= S_CNT_RD;
					end
				end
				S_CNT_RD: if (i_q == n) begin
					i_q <= '0;
					state_q <= S_SEED_RD;
				end else begin
					state_q <= S_CNT_WAIT;
				end
				S_CNT_WAIT: state_q <= S_CNT_UP;
				S_CNT_UP: begin
					i_q <= i_q + 1'b1;
					state_q <= S_CNT_RD;
				end
				S_SEED_RD: state_q <= (i_q == n) ? S_POP : S_SEED;
				S_SEED: begin
					i_q <= i_q + 1'b1;
					state_q <= S_SEED_RD;
				end
				S_POP: if (stat.q_empty) begin
					i_q <= '0;
					state_q <= S_EM_WAIT;
				end else begin
					state_q <= S_POP_RD;
				end
				S_POP_RD: begin
					node_q <= stat.q_node;
					state_q <= S_ADD_RD;
				end
				S_ADD_RD: state_q <= S_ADD;
				S_ADD: state_q <= S_POP;
				S_EM_WAIT: begin
					if (i_q == n) begin
						n <= '0;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_EM_OUT;
					end
				end
				S_EM_OUT: if (!out_valid) begin
					out_valid <= 1'b1;
					out_idx <= i_q[IDX_W-1:0];
					out_last <= (i_q + 1'b1 == n);
				end else if (out_ready) begin
					out_valid <= 1'b0;
					i_q <= i_q + 1'b1;
					state_q <= S_EM_WAIT;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) n <= CNT_W'(MAX_NODES))
		else $error("node count above limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_EM_OUT)
		else $error("result outside emit pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> {1'b0, out_idx} + 1'b1 == n)
		else $error("last flag on wrong node");
endmodule
